@@ hw/rtl/miller_rabin_witness_test_assert.svh @@
// Assertion macros for the RTL file that checks itself.
`ifndef MILLER_RABIN_WITNESS_TEST_ASSERT_SVH
`define MILLER_RABIN_WITNESS_TEST_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MRW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define MRW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/mrw_pkg.sv @@
`timescale 1ns / 1ps

package mrw_pkg;

  // Width of the numbers under test.
  localparam int NumberBits = 63;
  // Accumulator width: one bit of headroom for doubling and adding.
  localparam int AccBits = NumberBits + 1;
  // Counter width for the bits of a multiplier operand.
  localparam int BitIdxBits = $clog2(NumberBits);

  localparam int DataBytes = (2 * NumberBits + 7) / 8;

  // Verdict codes.
  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PROBABLE  = 2'd1,
    VERDICT_TRIVIAL   = 2'd2,
    VERDICT_BAD_BASE  = 2'd3
  } verdict_t;

  // Handshake between the sequencer and the modular multiplier.
  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

@@ hw/rtl/miller_rabin_witness_test.sv @@
`timescale 1ns / 1ps

// Miller-Rabin witness test for one candidate and one base.
// Input channel s_axis: tdata holds candidate (bits 62:0) and base
// (bits 125:63). Output channel m_axis: tdata holds the 2-bit verdict:
// 0 composite, 1 probable prime for this base, 2 trivially prime,
// 3 base out of range.
// One item is worked at a time; s_axis_tready is low from acceptance until
// the verdict has been taken. Small, even and bad-base cases are decided
// in ST_CHECK, which goes straight to ST_OUT.
// A full test is paced by the single bit-serial multiplier: up to two
// modular multiplications per bit of d plus up to s-1 squarings.
// A verdict is held on m_axis until m_axis_tready is high; the block waits
// and takes no new beat meanwhile. Reset (rst, synchronous) returns the
// sequencer to idle and drops any pending verdict.
module miller_rabin_witness_test (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // candidate [62:0], base [125:63], zero [127:126]
  input  logic [mrw_pkg::DataBytes*8-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // verdict [1:0], zero [7:2]
  output logic [7:0]                           m_axis_tdata
);
  import mrw_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_SPLIT  = 7'b0000100,
    ST_MUL_R  = 7'b0001000,
    ST_MUL_B  = 7'b0010000,
    ST_SQUARE = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t                state;
  logic [NumberBits-1:0] n;
  logic [NumberBits-1:0] base;
  logic [NumberBits-1:0] d;
  logic [NumberBits-1:0] r;
  logic [NumberBits-1:0] n_m1;
  logic [BitIdxBits-1:0] s_cnt;
  logic                  waiting;
  verdict_t              verdict;
  mul_ctrl_t             mctrl;
  mul_stat_t             mstat;
  logic [NumberBits-1:0] mul_a;
  logic [NumberBits-1:0] mul_b;
  logic [NumberBits-1:0] prod;

  assign n_m1 = n - 1'b1;

  // Shared multiplier: r*base, base*base or r*r.
  always_comb begin
    mul_a = r;
    mul_b = base;
    if (state == ST_MUL_B) begin
      mul_a = base;
    end else if (state == ST_SQUARE) begin
      mul_b = r;
    end
  end

  // In ST_MUL_R a product is only wanted for a set bit of a non-zero exponent.
  assign mctrl.start = ((state == ST_MUL_R && d != '0 && d[0]) || state == ST_MUL_B
                        || state == ST_SQUARE) && !waiting;

  mrw_mod_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mctrl),
    .stat    (mstat),
    .a       (mul_a),
    .b       (mul_b),
    .m       (n),
    .product (prod)
  );

  // Sequencer: checks, split of n-1, square-and-multiply, final squarings.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      waiting <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            n     <= s_axis_tdata[NumberBits-1:0];
            base  <= s_axis_tdata[2*NumberBits-1:NumberBits];
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          d     <= n_m1;
          s_cnt <= '0;
          r     <= NumberBits'(1);
          if (n <= NumberBits'(1)) begin
            verdict <= VERDICT_COMPOSITE;
            state   <= ST_OUT;
          end else if (n == NumberBits'(2) || n == NumberBits'(3)) begin
            verdict <= VERDICT_TRIVIAL;
            state   <= ST_OUT;
          end else if (!n[0]) begin
            verdict <= VERDICT_COMPOSITE;
            state   <= ST_OUT;
          end else if (base < NumberBits'(2) || base > n - NumberBits'(2)) begin
            verdict <= VERDICT_BAD_BASE;
            state   <= ST_OUT;
          end else begin
            state <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          // Strip trailing zeros of n-1, one per cycle.
          if (!d[0]) begin
            d     <= d >> 1;
            s_cnt <= s_cnt + 1'b1;
          end else if (d[0]) begin
            state <= ST_MUL_R;
          end
        end
        ST_MUL_R: begin
          if (d == '0) begin
            if (r == NumberBits'(1) || r == n_m1) begin
              verdict <= VERDICT_PROBABLE;
              state   <= ST_OUT;
            end else if (s_cnt <= BitIdxBits'(1)) begin
              verdict <= VERDICT_COMPOSITE;
              state   <= ST_OUT;
            end else begin
              s_cnt <= s_cnt - 1'b1;
              state <= ST_SQUARE;
            end
          end else if (!d[0]) begin
            state <= ST_MUL_B;
          end else if (!waiting) begin
            waiting <= 1'b1;
          end else if (mstat.done) begin
            waiting <= 1'b0;
            r       <= prod;
            state   <= ST_MUL_B;
          end
        end
        ST_MUL_B: begin
          if (!waiting) begin
            waiting <= 1'b1;
          end else if (mstat.done) begin
            waiting <= 1'b0;
            base    <= prod;
            d       <= d >> 1;
            state   <= ST_MUL_R;
          end
        end
        ST_SQUARE: begin
          if (!waiting) begin
            waiting <= 1'b1;
          end else if (mstat.done) begin
            waiting <= 1'b0;
            r       <= prod;
            if (prod == n_m1) begin
              verdict <= VERDICT_PROBABLE;
              state   <= ST_OUT;
            end else if (s_cnt == BitIdxBits'(1)) begin
              verdict <= VERDICT_COMPOSITE;
              state   <= ST_OUT;
            end else begin
              s_cnt <= s_cnt - 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {6'b0, verdict};

`include "miller_rabin_witness_test_assert.svh"

  `MRW_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid)
  `MRW_ASSERT_IMP(a_mul_idle_out, m_axis_tvalid, !mstat.busy)
  `MRW_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

@@ hw/rtl/mrw_mod_mul.sv @@
`timescale 1ns / 1ps

// Bit-serial interleaved modular multiplier: one bit of b per cycle,
// double the accumulator, reduce, add a, reduce.
module mrw_mod_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  mrw_pkg::mul_ctrl_t                 ctrl,
  output mrw_pkg::mul_stat_t                 stat,
  input  logic [mrw_pkg::NumberBits-1:0]     a,
  input  logic [mrw_pkg::NumberBits-1:0]     b,
  input  logic [mrw_pkg::NumberBits-1:0]     m,
  output logic [mrw_pkg::NumberBits-1:0]     product
);
  import mrw_pkg::*;

  logic [AccBits-1:0]    acc;
  logic [AccBits-1:0]    acc_next;
  logic [AccBits-1:0]    dbl;
  logic [AccBits-1:0]    dbl_red;
  logic [AccBits-1:0]    sum;
  logic [NumberBits-1:0] b_sh;
  logic [BitIdxBits-1:0] count;
  logic                  busy;
  logic                  done;

  // One step of the shift-and-add reduction.
  always_comb begin
    dbl     = {acc[AccBits-2:0], 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = dbl_red + {1'b0, a};
    if (b_sh[NumberBits-1]) begin
      acc_next = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
    end else begin
      acc_next = dbl_red;
    end
  end

  // Control: a counter over the operand bits, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy  <= 1'b1;
        count <= BitIdxBits'(NumberBits - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      acc  <= '0;
      b_sh <= b;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= {b_sh[NumberBits-2:0], 1'b0};
    end
  end

  assign product   = acc[NumberBits-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
